@@ sv/text_console_writer_core_defines.svh @@
// Assertion macros shared by the text console writer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`ifndef SYNTH
`define TCW_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcw: assertion failed");
`define TCW_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tcw: assertion failed");
`else
`define TCW_ASSERT_RST(lbl, clk, rst_n, prop)
`define TCW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
// No dependencies; used by every module of the block.
package tcw_pkg;

    localparam int COLS_DEF   = 80;
    localparam int ROWS_DEF   = 25;
    localparam int CELL_IDX_W = 11;
    localparam int CURSOR_W   = 11;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int WORD_W     = 16;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Decoupling queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = 1;
    localparam int Q_CW    = 2;

    typedef enum logic [2:0] {
        OP_READ     = 3'd0,
        OP_READ_OOR = 3'd1,
        OP_PUT      = 3'd2,
        OP_NEWLINE  = 3'd3,
        OP_RETURN   = 3'd4,
        OP_BACKSP   = 3'd5
    } t_op;

    typedef struct packed {
        logic                  cmd;
        logic [CHAR_W-1:0]     char_code;
        logic [CELL_IDX_W-1:0] cell_index;
    } t_cmd_item;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_pos;
        logic                scrolled;
        logic [WORD_W-1:0]   cell_word;
    } t_res_item;

    typedef struct packed {
        t_op                   op;
        logic [CHAR_W-1:0]     char_code;
        logic [CELL_IDX_W-1:0] cell_index;
    } t_qent;

endpackage

@@ sv/tcw_chan_if.sv @@
// Valid/ready channel carrying one payload beat of a chosen type.
// No dependencies; the payload type is set at instantiation.
interface tcw_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/text_console_writer_core.sv @@
// Top level of the text console writer: attribute register and the three stages.
// Depends on tcw_pkg, tcw_chan_if, tcw_front, tcw_queue and tcw_back.
//
// Usage:
//   i_cmd carries command beats {cmd, char_code, cell_index}; o_res returns one
//   result beat {cursor_pos, scrolled, cell_word} per command, in order.
//   i_cfg_we / i_cfg_wdata load the text attribute (reset value 7); write it
//   only while no command is in flight.
// Pipeline and throughput:
//   A put without a scroll passes the front register, the queue and the result register;
//   a read also waits in the read state on the registered read data of the screen memory.
//   Back to back, puts sustain one per cycle while o_res is ready; a read keeps the back
//   end from taking the next command until its data is in. A scroll moves one cell per cycle.
// Reset:
//   i_rst_n is synchronous, active low. Afterwards the back end clears the
//   screen memory, one cell per cycle, and i_cmd.ready stays low for that
//   time. Configuration writes are taken.
// Stall:
//   A result held on o_res keeps the back end from starting the next command;
//   the front register and a two-entry queue keep taking beats until full.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    tcw_chan_if.sink          i_cmd,
    tcw_chan_if.source        o_res
);
    logic [ATTR_W-1:0] r_text_attr;
    logic              w_clearing;

    // Front to queue, and queue to back.
    tcw_chan_if #(.T(t_qent)) w_fq ();
    tcw_chan_if #(.T(t_qent)) w_qb ();

    // Hold the attribute; load it on every configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_text_attr <= i_cfg_wdata;
        end
    end

    // Classify commands; stall intake while the screen is being cleared.
    tcw_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (w_clearing),
        .i_cmd   (i_cmd),
        .o_q     (w_fq)
    );

    // Decouple intake from execution.
    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq),
        .o_pop   (w_qb)
    );

    // Execute against the screen memory and the cursor.
    tcw_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text_attr (r_text_attr),
        .o_clearing  (w_clearing),
        .i_q         (w_qb),
        .o_res       (o_res)
    );
endmodule

@@ sv/tcw_front.sv @@
// Front stage: accepts command beats, classifies them into operations.
// Depends on tcw_pkg and tcw_chan_if.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_hold,
    tcw_chan_if.sink      i_cmd,
    tcw_chan_if.source    o_q
);
    localparam int CELLS = COLS * ROWS;

    logic  r_vld;
    t_qent r_ent;
    t_qent n_ent;
    logic  w_take;

    assign i_cmd.ready = (!r_vld || o_q.ready) && !i_hold;
    assign w_take      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_ent.char_code  = i_cmd.data.char_code;
        n_ent.cell_index = i_cmd.data.cell_index;
        if (i_cmd.data.cmd == CMD_READ) begin
            // Reads beyond the screen return zero; flag them here.
            n_ent.op = (32'(i_cmd.data.cell_index) < 32'(CELLS)) ? OP_READ : OP_READ_OOR;
        end else begin
            unique case (i_cmd.data.char_code)
                CH_NEWLINE:   n_ent.op = OP_NEWLINE;
                CH_RETURN:    n_ent.op = OP_RETURN;
                CH_BACKSPACE: n_ent.op = OP_BACKSP;
                default:      n_ent.op = OP_PUT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (o_q.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ent <= n_ent;
        end
    end

    assign o_q.valid = r_vld;
    assign o_q.data  = r_ent;
endmodule

@@ sv/tcw_queue.sv @@
// Short FIFO of classified operations between front and back.
// Depends on tcw_pkg and tcw_chan_if.
module tcw_queue
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcw_chan_if.sink   i_push,
    tcw_chan_if.source o_pop
);
    t_qent             r_buf [Q_DEPTH];
    logic [Q_PW-1:0]   r_wptr;
    logic [Q_PW-1:0]   r_rptr;
    logic [Q_CW-1:0]   r_cnt;
    logic              w_push;
    logic              w_pop;

    assign i_push.ready = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_pop.valid  = (r_cnt != '0);
    assign o_pop.data   = r_buf[r_rptr];
    assign w_push       = i_push.valid && i_push.ready;
    assign w_pop        = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + Q_PW'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + Q_PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + Q_CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - Q_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wptr] <= i_push.data;
        end
    end
endmodule

@@ sv/tcw_back.sv @@
// Back end: owns the screen memory, cursor, scroll and clear sweeps, result register.
// Depends on tcw_pkg, tcw_chan_if and the assertion macro header.
`include "text_console_writer_core_defines.svh"
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ATTR_W-1:0] i_text_attr,
    output logic              o_clearing,
    tcw_chan_if.sink          i_q,
    tcw_chan_if.source        o_res
);
    localparam int CELLS       = COLS * ROWS;
    localparam int SHIFT_CELLS = CELLS - COLS;
    localparam int AW          = $clog2(CELLS);
    localparam int XW          = AW + 1;
    localparam int SW          = $clog2(CELLS + 1);
    localparam int CLW         = $clog2(COLS);
    localparam int RW          = $clog2(ROWS + 1);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_SCROLL = 4'b1000
    } t_bstate;

    t_bstate           r_state, n_state;
    logic [AW-1:0]     r_cursor, n_cursor;
    logic [RW-1:0]     r_row, n_row;
    logic [CLW-1:0]    r_col, n_col;
    logic [SW-1:0]     r_scnt, n_scnt;
    logic              r_out_vld, n_out_vld;
    t_res_item         r_out, n_out;
    logic [WORD_W-1:0] r_mem [CELLS];
    logic [WORD_W-1:0] r_rdata;

    logic              w_slot_free;
    logic              w_take;
    logic [XW-1:0]     w_step_cur;
    logic [RW-1:0]     w_step_row;
    logic [CLW-1:0]    w_step_col;
    logic              w_wrap;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [SW-1:0]     w_rsum;

    assign w_slot_free = !r_out_vld || o_res.ready;
    assign i_q.ready   = (r_state == ST_IDLE) && w_slot_free;
    assign w_take      = i_q.valid && i_q.ready;
    assign o_clearing  = (r_state == ST_CLEAR);
    assign w_rsum      = r_scnt + SW'(COLS);

    // Cursor motion for the operation at the queue head.
    always_comb begin
        w_step_cur = XW'(r_cursor);
        w_step_row = r_row;
        w_step_col = r_col;
        case (i_q.data.op)
            OP_PUT: begin
                w_step_cur = XW'(r_cursor) + XW'(1);
                if (r_col == CLW'(COLS - 1)) begin
                    w_step_row = r_row + RW'(1);
                    w_step_col = '0;
                end else begin
                    w_step_col = r_col + CLW'(1);
                end
            end
            OP_NEWLINE: begin
                w_step_cur = XW'(r_cursor) - XW'(r_col) + XW'(COLS);
                w_step_row = r_row + RW'(1);
                w_step_col = '0;
            end
            OP_RETURN: begin
                w_step_cur = XW'(r_cursor) - XW'(r_col);
                w_step_col = '0;
            end
            OP_BACKSP: begin
                // At the first cell the cursor holds.
                if (r_cursor != '0) begin
                    w_step_cur = XW'(r_cursor) - XW'(1);
                    if (r_col == '0) begin
                        w_step_row = r_row - RW'(1);
                        w_step_col = CLW'(COLS - 1);
                    end else begin
                        w_step_col = r_col - CLW'(1);
                    end
                end
            end
            default: ;
        endcase
        w_wrap = (w_step_row == RW'(ROWS));
    end

    always_comb begin
        n_state   = r_state;
        n_cursor  = r_cursor;
        n_row     = r_row;
        n_col     = r_col;
        n_scnt    = r_scnt;
        n_out_vld = r_out_vld && !o_res.ready;
        n_out     = r_out;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;
        w_raddr   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_scnt);
                if (r_scnt == SW'(CELLS - 1)) begin
                    n_scnt  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_scnt = r_scnt + SW'(1);
                end
            end
            ST_IDLE: begin
                if (w_take) begin
                    unique case (i_q.data.op) inside
                        OP_READ: begin
                            w_raddr = AW'(i_q.data.cell_index);
                            n_state = ST_READ;
                        end
                        OP_READ_OOR: begin
                            n_out_vld        = 1'b1;
                            n_out.cursor_pos = CURSOR_W'(r_cursor);
                            n_out.scrolled   = 1'b0;
                            n_out.cell_word  = '0;
                        end
                        OP_PUT, OP_NEWLINE, OP_RETURN, OP_BACKSP: begin
                            w_we    = (i_q.data.op == OP_PUT) || (i_q.data.op == OP_BACKSP);
                            w_waddr = (i_q.data.op == OP_BACKSP) ? AW'(w_step_cur) : r_cursor;
                            w_wdata = {i_text_attr,
                                       (i_q.data.op == OP_PUT) ? i_q.data.char_code : '0};
                            n_col   = w_step_col;
                            if (w_wrap) begin
                                n_cursor = AW'(w_step_cur - XW'(COLS));
                                n_row    = RW'(ROWS - 1);
                                n_scnt   = '0;
                                n_state  = ST_SCROLL;
                            end else begin
                                n_cursor         = AW'(w_step_cur);
                                n_row            = w_step_row;
                                n_out_vld        = 1'b1;
                                n_out.cursor_pos = CURSOR_W'(w_step_cur);
                                n_out.scrolled   = 1'b0;
                                n_out.cell_word  = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                n_out_vld        = 1'b1;
                n_out.cursor_pos = CURSOR_W'(r_cursor);
                n_out.scrolled   = 1'b0;
                n_out.cell_word  = r_rdata;
                n_state          = ST_IDLE;
            end
            ST_SCROLL: begin
                // Read one row ahead, write the registered read data one row up; last row fills with zero.
                if (r_scnt < SW'(SHIFT_CELLS)) begin
                    w_raddr = w_rsum[AW-1:0];
                end
                if (r_scnt != '0) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_scnt - SW'(1));
                    w_wdata = (r_scnt <= SW'(SHIFT_CELLS)) ? r_rdata : '0;
                end
                if (r_scnt == SW'(CELLS)) begin
                    n_scnt           = '0;
                    n_state          = ST_IDLE;
                    n_out_vld        = 1'b1;
                    n_out.cursor_pos = CURSOR_W'(r_cursor);
                    n_out.scrolled   = 1'b1;
                    n_out.cell_word  = '0;
                end else begin
                    n_scnt = r_scnt + SW'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cursor  <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_scnt    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_row     <= n_row;
            r_col     <= n_col;
            r_scnt    <= n_scnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    `TCW_ASSERT_RST(a_cursor_on_screen, i_clk, i_rst_n, 32'(r_cursor) < 32'(CELLS))
    `TCW_ASSERT_RST(a_row_on_screen, i_clk, i_rst_n, 32'(r_row) < 32'(ROWS))
    `TCW_ASSERT_RST(a_cursor_matches_rc, i_clk, i_rst_n, 32'(r_cursor) == 32'(r_row) * COLS + 32'(r_col))
    `TCW_ASSERT_RST(a_scroll_reports, i_clk, i_rst_n, (r_state == ST_SCROLL) && (r_scnt == SW'(CELLS)) |=> r_out_vld && r_out.scrolled)
endmodule

@@ bench/text_console_writer_core_checker.sv @@
// Scoreboard for the text console writer: watches the command and result beats,
// keeps a shadow screen, cursor and attribute, and compares every result beat.
// Depends on tcw_pkg for the beat types and character codes.
module text_console_writer_core_checker
    import tcw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    input  logic      i_cmd_valid,
    input  logic      i_cmd_ready,
    input  t_cmd_item i_cmd_data,
    input  logic      i_res_valid,
    input  logic      i_res_ready,
    input  t_res_item i_res_data,
    output int        o_fail_count,
    output int        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = COLS_DEF;
    localparam int ROWS  = ROWS_DEF;
    localparam int CELLS = COLS * ROWS;

    logic [WORD_W-1:0] shadow_screen [CELLS];
    int unsigned       shadow_cursor;
    logic [ATTR_W-1:0] shadow_attr;
    t_res_item         pending_results [$];
    int                fail_total;

    // Apply one command beat to the shadow console and return its result beat.
    function automatic t_res_item console_step(t_cmd_item beat);
        t_res_item   res;
        int unsigned pos;
        res = '0;
        if (beat.cmd == CMD_READ) begin
            if (beat.cell_index < CELLS) res.cell_word = shadow_screen[beat.cell_index];
        end else begin
            pos = shadow_cursor;
            if (pos >= CELLS) pos = CELLS - 1;
            if (beat.char_code == CH_NEWLINE) begin
                pos = (pos / COLS + 1) * COLS;
            end else if (beat.char_code == CH_RETURN) begin
                pos = (pos / COLS) * COLS;
            end else if (beat.char_code == CH_BACKSPACE) begin
                if (pos > 0) pos--;
                shadow_screen[pos] = {shadow_attr, 8'h00};
            end else begin
                shadow_screen[pos] = {shadow_attr, beat.char_code};
                pos++;
            end
            if (pos >= CELLS) begin
                for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
                for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = '0;
                pos -= COLS;
                res.scrolled = 1'b1;
            end
            shadow_cursor = pos;
        end
        res.cursor_pos = CURSOR_W'(shadow_cursor);
        return res;
    endfunction

    task automatic compare_field(string name, logic [15:0] expv, logic [15:0] got);
        if (got !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) shadow_screen[i] = '0;
            shadow_cursor = 0;
            shadow_attr   = ATTR_RESET;
            pending_results.delete();
            fail_total = 0;
        end else begin
            if (i_cfg_we) shadow_attr = i_cfg_wdata;
            // Retire first: a result never leaves in the cycle its command enters.
            if (i_res_valid && i_res_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("cursor_pos", 16'(want.cursor_pos), 16'(i_res_data.cursor_pos));
                    compare_field("scrolled", 16'(want.scrolled), 16'(i_res_data.scrolled));
                    compare_field("cell_word", want.cell_word, i_res_data.cell_word);
                end
            end
            if (i_cmd_valid && i_cmd_ready) pending_results.push_back(console_step(i_cmd_data));
        end
        o_fail_count  <= fail_total;
        o_outstanding <= pending_results.size();
    end

endmodule

@@ bench/text_console_writer_core_tb.sv @@
// Top of the text console writer bench: clock, reset, command stimulus,
// result back-pressure, attribute phases and the verdict.
// Depends on tcw_pkg, tcw_chan_if, text_console_writer_core and its checker.
module text_console_writer_core_tb;
    import tcw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS         = COLS_DEF;
    localparam int ROWS         = ROWS_DEF;
    localparam int CELLS        = COLS * ROWS;
    localparam int RUN_PHASES   = 8;
    localparam int PHASE_BEATS  = 100;
    // Longest quiet stretch of a healthy run is a clearing pass or a scroll
    // plus the longest stalls; allow many times that.
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 16;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [ATTR_W-1:0] cfg_wdata;
    int                fail_count;
    int                outstanding;
    int                idle_cycles;
    int                phase_beats;
    bit                cmd_calm;
    bit                res_calm;

    tcw_chan_if #(.T(t_cmd_item)) cmd_ch ();
    tcw_chan_if #(.T(t_res_item)) res_ch ();

    always #4 i_clk = ~i_clk;

    text_console_writer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cmd       (cmd_ch),
        .o_res       (res_ch)
    );

    text_console_writer_core_checker scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_cmd_valid   (cmd_ch.valid),
        .i_cmd_ready   (cmd_ch.ready),
        .i_cmd_data    (cmd_ch.data),
        .i_res_valid   (res_ch.valid),
        .i_res_ready   (res_ch.ready),
        .i_res_data    (res_ch.data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Offer one command beat after a random gap and hold it until accepted.
    // Valid stays high on return, so a gap-free next beat follows without a
    // bubble; whoever comes next either re-drives it or drops it.
    task automatic push_command(logic cmd, logic [CHAR_W-1:0] ch, logic [CELL_IDX_W-1:0] idx);
        t_cmd_item beat;
        int        gap;
        beat.cmd        = cmd;
        beat.char_code  = ch;
        beat.cell_index = idx;
        if ($urandom_range(0, 39) == 0) cmd_calm = !cmd_calm;
        gap = cmd_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= beat;
        do @(posedge i_clk); while (!cmd_ch.ready);
        phase_beats++;
    endtask

    // Drop valid and hold until every expected result beat has come back.
    task automatic wait_quiet();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_attr(logic [ATTR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: stall a random number of cycles, then take one beat.
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        res_calm = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0) res_calm = !res_calm;
            stall = res_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [ATTR_W-1:0] phase_attr [RUN_PHASES];
        int                kind;
        int                len;
        int                sel;
        logic [CELL_IDX_W-1:0] probe;
        bit                first_seq;

        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        cmd_calm    = 1'b0;
        phase_beats = 0;
        first_seq   = 1'b1;

        phase_attr[0] = 8'h00;
        phase_attr[1] = 8'hFF;
        phase_attr[2] = 8'($urandom);
        phase_attr[3] = 8'h80;
        phase_attr[4] = 8'($urandom);
        phase_attr[5] = 8'h7F;
        phase_attr[6] = 8'h01;
        phase_attr[7] = 8'($urandom);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset attribute; the first waits out the
        // clearing pass through the handshake.
        push_command(CMD_PUT, 8'h41, '0);
        push_command(CMD_READ, 8'h00, 11'd0);
        push_command(CMD_PUT, CH_BACKSPACE, '0);    // step back onto cell 0
        push_command(CMD_PUT, CH_BACKSPACE, '1);    // backspace while already at cell 0
        push_command(CMD_READ, 8'hFF, 11'd0);
        push_command(CMD_PUT, 8'h00, '1);
        push_command(CMD_PUT, 8'hFF, '0);
        push_command(CMD_READ, 8'h00, 11'd1);
        push_command(CMD_PUT, CH_RETURN, '0);
        push_command(CMD_PUT, CH_NEWLINE, '0);
        push_command(CMD_PUT, 8'h5A, '0);
        push_command(CMD_READ, 8'h00, 11'(COLS));
        push_command(CMD_READ, 8'h00, 11'(CELLS - 1));
        push_command(CMD_READ, 8'h00, 11'(CELLS));  // first address past the screen
        push_command(CMD_READ, 8'hFF, '1);          // all index bits set, past the screen
        push_command(CMD_PUT, CH_RETURN, '0);
        push_command(CMD_PUT, CH_BACKSPACE, '0);    // wraps back to the end of row 0
        push_command(CMD_READ, 8'h00, 11'(COLS - 1));

        for (int ph = 0; ph < RUN_PHASES; ph++) begin
            wait_quiet();
            write_attr(phase_attr[ph]);
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS) begin
                kind = first_seq ? 82 : $urandom_range(0, 99);
                first_seq = 1'b0;
                if (kind < 45) begin
                    // Text line: mostly short, sometimes long enough to wrap.
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                                      : $urandom_range(1, 20);
                    repeat (len) begin
                        if ($urandom_range(0, 3) == 0)
                            push_command(CMD_PUT, 8'($urandom), 11'($urandom));
                        else
                            push_command(CMD_PUT, 8'($urandom_range(32, 126)), 11'($urandom));
                    end
                    push_command(CMD_PUT, ($urandom_range(0, 9) < 7) ? CH_NEWLINE : CH_RETURN,
                                 11'($urandom));
                end else if (kind < 60) begin
                    // Erase a few cells, then retype some.
                    repeat ($urandom_range(1, 6)) push_command(CMD_PUT, CH_BACKSPACE, 11'($urandom));
                    repeat ($urandom_range(0, 4))
                        push_command(CMD_PUT, 8'($urandom_range(32, 126)), 11'($urandom));
                end else if (kind < 80) begin
                    // Read probes, biased to the bottom rows where the text lands.
                    repeat ($urandom_range(1, 6)) begin
                        sel = $urandom_range(0, 9);
                        if (sel < 5)       probe = 11'($urandom_range(COLS * (ROWS - 3), CELLS - 1));
                        else if (sel < 7)  probe = 11'($urandom_range(0, CELLS - 1));
                        else if (sel == 7) probe = 11'($urandom_range(CELLS, 2047));
                        else if (sel == 8) probe = ($urandom_range(0, 1) == 0) ? 11'd0
                                                                               : 11'(CELLS - 1);
                        else               probe = 11'($urandom_range(0, 2 * COLS - 1));
                        push_command(CMD_READ, 8'($urandom), probe);
                    end
                end else if (kind < 85) begin
                    // Newline run: reach the bottom row and scroll repeatedly.
                    len = (kind == 82) ? ROWS + 1 : $urandom_range(1, 30);
                    repeat (len) push_command(CMD_PUT, CH_NEWLINE, 11'($urandom));
                end else begin
                    // Noise: every field drawn at random.
                    repeat ($urandom_range(1, 8))
                        push_command(1'($urandom), 8'($urandom), 11'($urandom));
                end
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_chan_if.sv
sv/tcw_front.sv
sv/tcw_queue.sv
sv/tcw_back.sv
sv/text_console_writer_core.sv
bench/text_console_writer_core_checker.sv
bench/text_console_writer_core_tb.sv
